FILE: design/dss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the dual stack in one shared word store.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;
  localparam int READ_W     = 32;
  localparam int SIZE_W     = 5;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_QUERY = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DONE = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic               stack_sel;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic                    we;
    logic                    re;
    logic [ADDR_W-1:0]       addr;
    logic [DATA_WIDTH-1:0]   wdata;
  } mem_req_t;

  typedef struct packed {
    logic signed [READ_W-1:0] read_value;
    logic [1:0]               status;
    logic [SIZE_W-1:0]        size_a;
    logic [SIZE_W-1:0]        size_b;
    logic                     empty_a;
    logic                     empty_b;
    logic                     store_full;
  } res_t;

endpackage

FILE: design/dss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_if
// Request and response channels of the dual stack, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dss_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic               stack_sel;
  logic signed [31:0] push_value;

  modport source (output valid, output action, output stack_sel, output push_value,
                  input ready);
  modport sink   (input valid, input action, input stack_sel, input push_value,
                  output ready);
endinterface

interface dss_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [1:0]         status;
  logic [4:0]         size_a;
  logic [4:0]         size_b;
  logic               empty_a;
  logic               empty_b;
  logic               store_full;

  modport source (output valid, output read_value, output status, output size_a,
                  output size_b, output empty_a, output empty_b, output store_full,
                  input ready);
  modport sink   (input valid, input read_value, input status, input size_a,
                  input size_b, input empty_a, input empty_b, input store_full,
                  output ready);
endinterface

FILE: design/dss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: design/dss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_ctrl
// Stack counters, access sequencer and result build for the shared store.
// ----------------------------------------------------------------------------
module dss_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dss_pkg::req_t                       req,
  output dss_pkg::mem_req_t                   mem_req,
  input  logic [dss_pkg::DATA_WIDTH-1:0]      mem_rdata,
  output logic                                res_valid,
  input  logic                                slot_free,
  output dss_pkg::res_t                       res
);

  localparam logic [dss_pkg::CNT_W-1:0] DEPTH_C = dss_pkg::CNT_W'(dss_pkg::DEPTH);

  dss_pkg::state_t               state;
  dss_pkg::state_t               state_next;
  logic [dss_pkg::CNT_W-1:0]     count_a;
  logic [dss_pkg::CNT_W-1:0]     count_a_next;
  logic [dss_pkg::CNT_W-1:0]     count_b;
  logic [dss_pkg::CNT_W-1:0]     count_b_next;
  dss_pkg::status_t              status_q;
  dss_pkg::status_t              status_next;
  logic                          rd_pend;
  logic                          rd_pend_next;

  logic                          accept;
  dss_pkg::act_t                 act;
  logic [dss_pkg::SUM_W-1:0]     sum;
  logic                          full_now;
  logic [dss_pkg::CNT_W-1:0]     cnt_sel;
  logic [dss_pkg::CNT_W-1:0]     b_push_cnt;
  logic [dss_pkg::CNT_W-1:0]     b_push_idx;
  logic [dss_pkg::CNT_W-1:0]     b_top_idx;
  logic [dss_pkg::CNT_W-1:0]     a_top_idx;
  logic signed [63:0]            push_ext;
  logic signed [63:0]            rd_ext;
  logic [dss_pkg::SUM_W-1:0]     sum_q;

  assign accept     = in_valid && in_ready;
  assign act        = dss_pkg::act_t'(req.action);
  assign sum        = {1'b0, count_a} + {1'b0, count_b};
  assign full_now   = sum >= dss_pkg::SUM_W'(dss_pkg::DEPTH);
  assign cnt_sel    = req.stack_sel ? count_b : count_a;
  assign b_push_cnt = count_b + dss_pkg::CNT_W'(1);
  assign b_push_idx = DEPTH_C - b_push_cnt;
  assign b_top_idx  = DEPTH_C - count_b;
  assign a_top_idx  = count_a - dss_pkg::CNT_W'(1);
  assign push_ext   = 64'(req.push_value);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dss_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = dss_pkg::S_DONE;
        end
      end
      dss_pkg::S_DONE: begin
        if (slot_free) begin
          state_next = dss_pkg::S_IDLE;
        end
      end
      default: state_next = dss_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      dss_pkg::S_IDLE: in_ready  = 1'b1;
      dss_pkg::S_DONE: res_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
      end
    endcase
  end

  // item decode, counter update and store access
  always_comb begin
    count_a_next  = count_a;
    count_b_next  = count_b;
    status_next   = status_q;
    rd_pend_next  = rd_pend;
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.addr  = '0;
    mem_req.wdata = push_ext[dss_pkg::DATA_WIDTH-1:0];
    if (accept) begin
      status_next  = dss_pkg::ST_OK;
      rd_pend_next = 1'b0;
      unique case (act)
        dss_pkg::ACT_PUSH: begin
          if (full_now) begin
            status_next = dss_pkg::ST_FULL;
          end else begin
            mem_req.we = 1'b1;
            if (req.stack_sel) begin
              mem_req.addr = b_push_idx[dss_pkg::ADDR_W-1:0];
              count_b_next = b_push_cnt;
            end else begin
              mem_req.addr = count_a[dss_pkg::ADDR_W-1:0];
              count_a_next = count_a + dss_pkg::CNT_W'(1);
            end
          end
        end
        dss_pkg::ACT_POP, dss_pkg::ACT_PEEK: begin
          if (cnt_sel == '0) begin
            status_next = dss_pkg::ST_EMPTY;
          end else begin
            mem_req.re   = 1'b1;
            rd_pend_next = 1'b1;
            if (req.stack_sel) begin
              mem_req.addr = b_top_idx[dss_pkg::ADDR_W-1:0];
              if (act == dss_pkg::ACT_POP) begin
                count_b_next = count_b - dss_pkg::CNT_W'(1);
              end
            end else begin
              mem_req.addr = a_top_idx[dss_pkg::ADDR_W-1:0];
              if (act == dss_pkg::ACT_POP) begin
                count_a_next = a_top_idx;
              end
            end
          end
        end
        dss_pkg::ACT_QUERY: begin
          status_next = dss_pkg::ST_OK;
        end
        default: status_next = dss_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dss_pkg::S_IDLE;
      count_a  <= '0;
      count_b  <= '0;
      status_q <= dss_pkg::ST_OK;
      rd_pend  <= 1'b0;
    end else begin
      state    <= state_next;
      count_a  <= count_a_next;
      count_b  <= count_b_next;
      status_q <= status_next;
      rd_pend  <= rd_pend_next;
    end
  end

  // result from the settled counters and the registered read word
  assign rd_ext = 64'($signed(mem_rdata));
  assign sum_q  = {1'b0, count_a} + {1'b0, count_b};

  always_comb begin
    res.read_value = rd_pend ? rd_ext[dss_pkg::READ_W-1:0] : '1;
    res.status     = status_q;
    res.size_a     = dss_pkg::SIZE_W'(count_a);
    res.size_b     = dss_pkg::SIZE_W'(count_b);
    res.empty_a    = (count_a == '0);
    res.empty_b    = (count_b == '0);
    res.store_full = sum_q >= dss_pkg::SUM_W'(dss_pkg::DEPTH);
  end

endmodule

FILE: design/dual_stack_shared_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_shared_buffer
// Two LIFO stacks in one shared word store, one growing up, one growing down.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  req      sink       action, stack_sel, push_value
//  rsp      source     read_value, status, size_a, size_b, empty_a,
//                      empty_b, store_full
//
//  one request at a time: the store access takes place in the accept cycle,
//  then, in the S_DONE state, the registered read word and the updated
//  counters form the result and move into the output register once it is
//  free, which raises rsp.valid
//  the input is closed in the S_DONE state, and stays closed while the
//  output register still holds an earlier result that has not been taken
//  reset clears both counters and the handshake; the store is not cleared
// ----------------------------------------------------------------------------
module dual_stack_shared_buffer (
  input  logic       clk,
  input  logic       rst,
  dss_req_if.sink    req,
  dss_rsp_if.source  rsp
);

  dss_pkg::req_t                     req_pay;
  dss_pkg::mem_req_t                 mem_req;
  logic [dss_pkg::DATA_WIDTH-1:0]    mem_rdata;
  logic                              res_valid;
  logic                              slot_free;
  dss_pkg::res_t                     res;
  logic                              out_valid;
  dss_pkg::res_t                     out_res;

  assign req_pay.action     = req.action;
  assign req_pay.stack_sel  = req.stack_sel;
  assign req_pay.push_value = req.push_value;

  assign slot_free = !out_valid || rsp.ready;

  dss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .req       (req_pay),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .slot_free (slot_free),
    .res       (res)
  );

  dss_ram #(
    .WIDTH (dss_pkg::DATA_WIDTH),
    .DEPTH (dss_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .re    (mem_req.re),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && slot_free) begin
      out_res <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_res.read_value;
  assign rsp.status     = out_res.status;
  assign rsp.size_a     = out_res.size_a;
  assign rsp.size_b     = out_res.size_b;
  assign rsp.empty_a    = out_res.empty_a;
  assign rsp.empty_b    = out_res.empty_b;
  assign rsp.store_full = out_res.store_full;

endmodule

FILE: verif/dss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_checker
// Watches the request and response channels of the dual stack. It keeps its
// own copy of both stacks and the shared word store, works out the result of
// every accepted request and compares each accepted response, field by field,
// against the oldest outstanding result. Reports error and outstanding counts.
// ----------------------------------------------------------------------------
module dss_checker (
  input  logic clk,
  input  logic rst,
  dss_req_if   req,
  dss_rsp_if   rsp,
  output int   errors,
  output int   pending
);
  import dss_pkg::*;

  logic signed [DATA_WIDTH-1:0] word_mem [DEPTH];
  int   depth_a = 0;
  int   depth_b = 0;
  int   err_count = 0;
  int   outstanding = 0;
  res_t result_q [$];

  assign errors  = err_count;
  assign pending = outstanding;

  function automatic res_t stack_op(act_t act, logic sel, logic signed [31:0] value);
    res_t r;
    int   slot;
    r.read_value = -1;
    r.status     = ST_OK;
    case (act)
      ACT_PUSH: begin
        if (depth_a + depth_b >= DEPTH) begin
          r.status = ST_FULL;
        end else if (!sel) begin
          word_mem[depth_a] = value;
          depth_a++;
        end else begin
          depth_b++;
          word_mem[DEPTH - depth_b] = value;
        end
      end
      ACT_POP, ACT_PEEK: begin
        if ((sel ? depth_b : depth_a) == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot = sel ? DEPTH - depth_b : depth_a - 1;
          r.read_value = word_mem[slot];
          if (act == ACT_POP) begin
            if (sel) depth_b--;
            else     depth_a--;
          end
        end
      end
      default: ;
    endcase
    r.size_a     = depth_a[SIZE_W-1:0];
    r.size_b     = depth_b[SIZE_W-1:0];
    r.empty_a    = (depth_a == 0);
    r.empty_b    = (depth_b == 0);
    r.store_full = (depth_a + depth_b >= DEPTH);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst) begin
      if (req.valid && req.ready)
        result_q.push_back(stack_op(act_t'(req.action), req.stack_sel, req.push_value));
      if (rsp.valid && rsp.ready) begin
        if (result_q.size() == 0) begin
          err_count++;
          $display("%0t: response with no result outstanding", $time);
        end else begin
          want = result_q.pop_front();
          check_field("read_value", want.read_value, rsp.read_value);
          check_field("status", 32'(want.status), 32'(rsp.status));
          check_field("size_a", 32'(want.size_a), 32'(rsp.size_a));
          check_field("size_b", 32'(want.size_b), 32'(rsp.size_b));
          check_field("empty_a", 32'(want.empty_a), 32'(rsp.empty_a));
          check_field("empty_b", 32'(want.empty_b), 32'(rsp.empty_b));
          check_field("store_full", 32'(want.store_full), 32'(rsp.store_full));
        end
      end
    end
    outstanding <= result_q.size();
  end

endmodule

FILE: verif/tb_dual_stack_shared_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_stack_shared_buffer
// Drives push, pop, peek and query requests into the dual stack: a directed
// pass over empty, full and extreme-value cases, then bursts that fill and
// drain both stacks with random data, under changing idle patterns on both
// channels and one long response hold-off. Checking is done by dss_checker.
// ----------------------------------------------------------------------------
module tb_dual_stack_shared_buffer;
  import dss_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 400;
  localparam int TAIL_CYCLES  = 10;

  logic clk;
  logic rst;
  int   send_idle;
  int   rcv_idle;
  int   err_count;
  int   pending;
  int   stall_cycles = 0;
  bit   hold_off;

  dss_req_if req_ch ();
  dss_rsp_if rsp_ch ();

  dual_stack_shared_buffer u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  dss_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (err_count),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // response side
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input act_t act, input logic sel, input logic [31:0] value);
    if ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.stack_sel  <= sel;
    req_ch.push_value <= value;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int   roll;
    int   burst_left;
    bit   filling;
    act_t act;

    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.action     <= ACT_QUERY;
    req_ch.stack_sel  <= 1'b0;
    req_ch.push_value <= '0;
    send_idle  = 18;
    rcv_idle   = 66;
    hold_off   = 1'b0;
    burst_left = 0;
    filling    = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty stacks
    send_item(ACT_POP, 1'b0, 32'h0);
    send_item(ACT_PEEK, 1'b1, 32'h0);
    send_item(ACT_QUERY, 1'b0, 32'h0);
    // extreme words
    send_item(ACT_PUSH, 1'b0, 32'h8000_0000);
    send_item(ACT_PUSH, 1'b1, 32'h7fff_ffff);
    send_item(ACT_PEEK, 1'b0, 32'h0);
    send_item(ACT_POP, 1'b1, 32'h0);
    send_item(ACT_QUERY, 1'b1, 32'ha5a5_5a5a);
    // fill until the tops meet, then refused pushes
    for (int i = 0; i < DEPTH - 1; i++)
      send_item(ACT_PUSH, i[0], (i % 2) ? 32'hffff_ffff : 32'h0000_0000 + i);
    send_item(ACT_PUSH, 1'b0, 32'h1234_5678);
    send_item(ACT_PUSH, 1'b1, 32'h1234_5678);
    send_item(ACT_PEEK, 1'b1, 32'h0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle = 18; rcv_idle = 66; end
        1:       begin send_idle = 66; rcv_idle = 18; end
        default: begin send_idle = 0;  rcv_idle = 0;  hold_off = 1'b1; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          filling    = 1'($urandom_range(1));
          burst_left = $urandom_range(40, 5);
        end
        burst_left--;
        roll = $urandom_range(99);
        if (filling)
          act = (roll < 65) ? ACT_PUSH : (roll < 80) ? ACT_POP :
                (roll < 93) ? ACT_PEEK : ACT_QUERY;
        else
          act = (roll < 55) ? ACT_POP : (roll < 70) ? ACT_PEEK :
                (roll < 90) ? ACT_PUSH : ACT_QUERY;
        send_item(act, 1'($urandom_range(1)), pick_word());
      end
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
design/dss_pkg.sv
design/dss_if.sv
design/dss_ram.sv
design/dss_ctrl.sv
design/dual_stack_shared_buffer.sv
verif/dss_checker.sv
verif/tb_dual_stack_shared_buffer.sv
